FILE: rtl/stop_and_wait_segment_receiver_unit_macros.svh
// assertion helpers shared by the receiver modules
// each macro expects clk and rst_n in scope
`ifndef STOP_AND_WAIT_SEGMENT_RECEIVER_UNIT_MACROS_SVH
`define STOP_AND_WAIT_SEGMENT_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication
`define SAWR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAWR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sawr_pkg.sv
`default_nettype none

package sawr_pkg;

  // widths of the fixed fields
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned BYTE_W = 8;

  // beat layout on the stream ports
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 64;

  // result queue
  localparam int unsigned RQ_DEPTH = 8;
  localparam int unsigned RQ_PTR_W = 3;
  localparam int unsigned RQ_CNT_W = 4;

  // item operation codes
  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // verdict status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_CHK_ERR  = 2'd1;
  localparam logic [1:0] ST_BAD_SEQ  = 2'd2;

  // one input item
  typedef struct packed {
    logic              operation;
    logic [WORD_W-1:0] seq_no;          // signed
    logic [WORD_W-1:0] ack_no;          // signed
    logic [WORD_W-1:0] header_checksum; // signed
    logic              last_segment;
    logic [WORD_W-1:0] payload_length;  // signed
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [1:0]        status;
    logic              send_ack;
    logic              ack_number;
    logic              ack_checksum;
    logic [WORD_W-1:0] packets_accepted;
    logic              transfer_done;
    logic              last_of_run;
  } res_t;

  // up to two results written into the queue in one cycle, first one first
  typedef struct packed {
    logic v0;
    res_t r0;
    logic v1;
    res_t r1;
  } push_t;

endpackage

`default_nettype wire

FILE: rtl/sawr_fifo.sv
`default_nettype none

module sawr_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sawr_pkg::push_t               push,
  output logic [sawr_pkg::RQ_CNT_W-1:0]      count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sawr_pkg::res_t                     out_res
);
  import sawr_pkg::*;

  res_t                mem_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r;
  logic [RQ_PTR_W-1:0] wr_ptr_nxt;
  logic [RQ_PTR_W-1:0] rd_ptr_r;
  logic [RQ_PTR_W-1:0] rd_ptr_nxt;
  logic [RQ_CNT_W-1:0] count_r;
  logic [RQ_CNT_W-1:0] count_nxt;
  logic [RQ_PTR_W-1:0] wr_ptr_1;
  logic [1:0]          push_n;
  logic                pop;

  // handshake and counts
  assign pop       = out_valid && out_ready;
  assign push_n    = {1'b0, push.v0} + {1'b0, push.v1};
  assign wr_ptr_1  = wr_ptr_r + RQ_PTR_W'(1);
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + RQ_PTR_W'(pop);
    count_nxt  = count_r + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, two writes at consecutive slots
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_1] <= push.r1;
    end
  end

  `include "stop_and_wait_segment_receiver_unit_macros.svh"

  `SAWR_ASSERT_IMP(a_no_overflow, push_n != 2'd0, ({1'b0, count_r} + {3'b0, push_n}) <= (RQ_CNT_W + 1)'(RQ_DEPTH), "result queue overflow")
  `SAWR_ASSERT_IMP(a_second_after_first, push.v1, push.v0, "second result pushed without a first")
  `SAWR_ASSERT_NXT(a_count_tracks, pop && (push_n == 2'd0), count_r == $past(count_r) - RQ_CNT_W'(1), "queue count lost a pop")

endmodule

`default_nettype wire

FILE: rtl/sawr_proc.sv
`default_nettype none

module sawr_proc #(
  parameter int unsigned PAYLOAD_BYTES = 1046
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sawr_pkg::item_t               in_item,
  input  wire logic [sawr_pkg::RQ_CNT_W-1:0] q_count,
  output sawr_pkg::push_t                    push
);
  import sawr_pkg::*;

  localparam logic [IDX_W-1:0]  PB      = IDX_W'(PAYLOAD_BYTES);
  localparam logic [IDX_W-1:0]  PB_LAST = IDX_W'(PAYLOAD_BYTES - 1);
  localparam logic [WORD_W-1:0] PB_WORD = WORD_W'(PAYLOAD_BYTES);

  // input register
  logic  s1_valid_r;
  item_t s1_item_r;

  // segment state
  logic              expected_bit_r,   expected_bit_nxt;
  logic [WORD_W-1:0] running_xor_r,    running_xor_nxt;
  logic [WORD_W-1:0] held_seq_r,       held_seq_nxt;
  logic [WORD_W-1:0] held_checksum_r,  held_checksum_nxt;
  logic              held_last_r,      held_last_nxt;
  logic [IDX_W-1:0]  held_length_r,    held_length_nxt;
  logic [IDX_W-1:0]  byte_counter_r,   byte_counter_nxt;
  logic [WORD_W-1:0] accepted_count_r, accepted_count_nxt;

  logic [RQ_CNT_W:0] occ;
  logic              in_accept;
  logic              is_header;
  logic              is_byte;
  logic [WORD_W-1:0] byte_xor;
  logic              has_data;
  logic              has_verdict;
  logic              chk_bad;
  logic              seq_bad;
  logic              verdict_ok;
  res_t              data_res;
  res_t              verdict_res;

  // take a beat only if the queue can absorb two results from it and from the one in flight
  assign occ       = {1'b0, q_count} + {{(RQ_CNT_W - 1){1'b0}}, s1_valid_r, 1'b0};
  assign in_ready  = rst_n && (occ <= (RQ_CNT_W + 1)'(RQ_DEPTH - 2));
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
  end

  // decode of the registered item
  assign is_header   = s1_valid_r && (s1_item_r.operation == OP_HEADER);
  assign is_byte     = s1_valid_r && (s1_item_r.operation == OP_PAYLOAD) && (byte_counter_r < PB);
  assign byte_xor    = running_xor_r ^ {{(WORD_W - BYTE_W){s1_item_r.data_byte[BYTE_W-1]}},
                                        s1_item_r.data_byte};
  assign has_data    = is_byte && (byte_counter_r < held_length_r);
  assign has_verdict = is_byte && (byte_counter_r == PB_LAST);
  assign chk_bad     = (held_checksum_r != byte_xor);
  assign seq_bad     = (held_seq_r != {{(WORD_W - 1){1'b0}}, expected_bit_r});
  assign verdict_ok  = has_verdict && !chk_bad && !seq_bad;

  // state update
  always_comb begin
    expected_bit_nxt   = expected_bit_r;
    running_xor_nxt    = running_xor_r;
    held_seq_nxt       = held_seq_r;
    held_checksum_nxt  = held_checksum_r;
    held_last_nxt      = held_last_r;
    held_length_nxt    = held_length_r;
    byte_counter_nxt   = byte_counter_r;
    accepted_count_nxt = accepted_count_r;
    if (is_header) begin
      running_xor_nxt   = s1_item_r.seq_no ^ s1_item_r.ack_no ^
                          {{(WORD_W - 1){1'b0}}, s1_item_r.last_segment} ^
                          s1_item_r.payload_length;
      held_seq_nxt      = s1_item_r.seq_no;
      held_checksum_nxt = s1_item_r.header_checksum;
      held_last_nxt     = s1_item_r.last_segment;
      // clamp the length to 0..PAYLOAD_BYTES
      priority if (s1_item_r.payload_length[WORD_W-1]) begin
        held_length_nxt = '0;
      end else if (s1_item_r.payload_length > PB_WORD) begin
        held_length_nxt = PB;
      end else begin
        held_length_nxt = s1_item_r.payload_length[IDX_W-1:0];
      end
      byte_counter_nxt = '0;
    end else if (is_byte) begin
      running_xor_nxt  = byte_xor;
      byte_counter_nxt = byte_counter_r + IDX_W'(1);
      if (verdict_ok) begin
        expected_bit_nxt   = ~expected_bit_r;
        accepted_count_nxt = accepted_count_r + WORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_bit_r   <= 1'b0;
      running_xor_r    <= '0;
      held_seq_r       <= '0;
      held_checksum_r  <= '0;
      held_last_r      <= 1'b0;
      held_length_r    <= '0;
      byte_counter_r   <= '0;
      accepted_count_r <= '0;
    end else begin
      expected_bit_r   <= expected_bit_nxt;
      running_xor_r    <= running_xor_nxt;
      held_seq_r       <= held_seq_nxt;
      held_checksum_r  <= held_checksum_nxt;
      held_last_r      <= held_last_nxt;
      held_length_r    <= held_length_nxt;
      byte_counter_r   <= byte_counter_nxt;
      accepted_count_r <= accepted_count_nxt;
    end
  end

  // tentative data result
  always_comb begin
    data_res             = '0;
    data_res.kind        = KIND_DATA;
    data_res.out_byte    = s1_item_r.data_byte;
    data_res.byte_index  = byte_counter_r;
    data_res.last_of_run = !has_verdict;
  end

  // verdict result
  always_comb begin
    verdict_res                  = '0;
    verdict_res.kind             = KIND_VERDICT;
    verdict_res.last_of_run      = 1'b1;
    verdict_res.packets_accepted = accepted_count_r;
    priority if (chk_bad) begin
      verdict_res.status = ST_CHK_ERR;
    end else if (seq_bad) begin
      verdict_res.status       = ST_BAD_SEQ;
      verdict_res.send_ack     = 1'b1;
      verdict_res.ack_number   = expected_bit_r;
      verdict_res.ack_checksum = ~expected_bit_r;
    end else begin
      verdict_res.status           = ST_ACCEPTED;
      verdict_res.send_ack         = 1'b1;
      verdict_res.ack_number       = ~expected_bit_r;
      verdict_res.ack_checksum     = expected_bit_r;
      verdict_res.packets_accepted = accepted_count_r + WORD_W'(1);
      verdict_res.transfer_done    = held_last_r;
    end
  end

  // pack results in order into the queue write
  always_comb begin
    push.v0 = has_data || has_verdict;
    push.r0 = has_data ? data_res : verdict_res;
    push.v1 = has_data && has_verdict;
    push.r1 = verdict_res;
  end

  `include "stop_and_wait_segment_receiver_unit_macros.svh"

  `SAWR_ASSERT_IMP(a_counter_bound, 1'b1, byte_counter_r <= PB, "byte counter past segment size")
  `SAWR_ASSERT_NXT(a_bit_toggles, verdict_ok, expected_bit_r != $past(expected_bit_r), "expected bit did not toggle on accept")

endmodule

`default_nettype wire

FILE: rtl/stop_and_wait_segment_receiver_unit.sv
// Stop-and-wait segment receiver. A segment is one header beat (in_tuser = 0) followed by
// exactly PAYLOAD_BYTES payload beats (in_tuser = 1). Payload bytes below the clamped length
// come out at once as tentative data results (out_tuser = 0); the last payload beat also
// yields a verdict result (out_tuser = 1) with status, ack to send and the accepted count.
// out_tlast marks the final result caused by one input beat. One beat is taken every cycle
// while in_tready is high; the path is an input register, combinational checksum, counter
// and verdict logic, and an 8-entry result queue. Only a stall on the result side holds off
// input, once the queue has fewer than two free slots beyond the beat in flight.
`default_nettype none

module stop_and_wait_segment_receiver_unit #(
  parameter int unsigned PAYLOAD_BYTES = 1046
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // seq_no[31:0], ack_no[63:32], header_checksum[95:64], last_segment[96],
  // payload_length[128:97], data_byte[136:129], zero fill[143:137]
  input  wire logic [sawr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation[0]
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_byte[7:0], byte_index[18:8], status[20:19], send_ack[21], ack_number[22],
  // ack_checksum[23], packets_accepted[55:24], transfer_done[56], zero fill[63:57]
  output logic [sawr_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // kind[0]
  output logic                                    out_tuser,
  output logic                                    out_tlast
);
  import sawr_pkg::*;

  item_t               in_item;
  push_t               push;
  res_t                out_res;
  logic [RQ_CNT_W-1:0] q_count;

  // unpack the input beat
  assign in_item.operation       = in_tuser;
  assign in_item.seq_no          = in_tdata[31:0];
  assign in_item.ack_no          = in_tdata[63:32];
  assign in_item.header_checksum = in_tdata[95:64];
  assign in_item.last_segment    = in_tdata[96];
  assign in_item.payload_length  = in_tdata[128:97];
  assign in_item.data_byte       = in_tdata[136:129];

  sawr_proc #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_proc (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_count  (q_count),
    .push     (push)
  );

  sawr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .count     (q_count),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // pack the result beat
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last_of_run;
  assign out_tdata = {7'b0,
                      out_res.transfer_done,
                      out_res.packets_accepted,
                      out_res.ack_checksum,
                      out_res.ack_number,
                      out_res.send_ack,
                      out_res.status,
                      out_res.byte_index,
                      out_res.out_byte};

endmodule

`default_nettype wire

FILE: test/tb.sv
import sawr_pkg::*;

localparam int unsigned SEG_BYTES = 1046;

// mirror of the receiver: segment state, ack bit, accepted count and owed results
class segment_tracker;
  logic        want_bit;
  logic [31:0] xor_acc;
  logic [31:0] hdr_seq;
  logic [31:0] hdr_chk;
  logic        hdr_last;
  logic [10:0] hdr_len;
  logic [10:0] byte_cnt;
  logic [31:0] accepted;
  res_t        outbox[$];
  int          bad_count;

  // reset state; payload before any header sees an all-zero header
  function new();
    want_bit  = 1'b0;
    xor_acc   = '0;
    hdr_seq   = '0;
    hdr_chk   = '0;
    hdr_last  = 1'b0;
    hdr_len   = '0;
    byte_cnt  = '0;
    accepted  = '0;
    bad_count = 0;
  endfunction

  task flag(string what);
    $display("error at %0t: %s", $time, what);
    bad_count++;
  endtask

  // accepted input beat: update state and queue the results it causes
  function void take_beat(item_t it);
    res_t r;
    int   start;
    start = outbox.size();
    // header restarts the segment, dropping any partial one
    if (it.operation == OP_HEADER) begin
      xor_acc  = it.seq_no ^ it.ack_no ^ {31'b0, it.last_segment} ^ it.payload_length;
      hdr_seq  = it.seq_no;
      hdr_chk  = it.header_checksum;
      hdr_last = it.last_segment;
      if (it.payload_length[31]) begin
        hdr_len = '0;
      end else if (it.payload_length > SEG_BYTES) begin
        hdr_len = 11'(SEG_BYTES);
      end else begin
        hdr_len = it.payload_length[10:0];
      end
      byte_cnt = '0;
      return;
    end
    // surplus bytes after a full segment are dropped
    if (byte_cnt >= SEG_BYTES) return;
    xor_acc = xor_acc ^ {{24{it.data_byte[7]}}, it.data_byte};
    // tentative data for bytes inside the length
    if (byte_cnt < hdr_len) begin
      r            = '0;
      r.kind       = KIND_DATA;
      r.out_byte   = it.data_byte;
      r.byte_index = byte_cnt;
      outbox.push_back(r);
    end
    // verdict on the final byte
    if (byte_cnt == SEG_BYTES - 1) begin
      r                  = '0;
      r.kind             = KIND_VERDICT;
      r.packets_accepted = accepted;
      if (hdr_chk != xor_acc) begin
        r.status = ST_CHK_ERR;
      end else if (hdr_seq != {31'b0, want_bit}) begin
        r.status       = ST_BAD_SEQ;
        r.send_ack     = 1'b1;
        r.ack_number   = want_bit;
        r.ack_checksum = ~want_bit;
      end else begin
        want_bit           = ~want_bit;
        accepted           = accepted + 32'd1;
        r.status           = ST_ACCEPTED;
        r.send_ack         = 1'b1;
        r.ack_number       = want_bit;
        r.ack_checksum     = ~want_bit;
        r.packets_accepted = accepted;
        r.transfer_done    = hdr_last;
      end
      outbox.push_back(r);
    end
    byte_cnt = byte_cnt + 11'd1;
    if (outbox.size() > start) outbox[outbox.size() - 1].last_of_run = 1'b1;
  endfunction

  task field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  // result beat against the oldest owed result
  task match_result(res_t got);
    res_t want;
    if (outbox.size() == 0) begin
      flag($sformatf("result beat with nothing owed, kind %0d", got.kind));
      return;
    end
    want = outbox.pop_front();
    field("kind", 32'(got.kind), 32'(want.kind));
    field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
    field("byte_index", 32'(got.byte_index), 32'(want.byte_index));
    field("status", 32'(got.status), 32'(want.status));
    field("send_ack", 32'(got.send_ack), 32'(want.send_ack));
    field("ack_number", 32'(got.ack_number), 32'(want.ack_number));
    field("ack_checksum", 32'(got.ack_checksum), 32'(want.ack_checksum));
    field("packets_accepted", got.packets_accepted, want.packets_accepted);
    field("transfer_done", 32'(got.transfer_done), 32'(want.transfer_done));
    field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
  endtask
endclass

module tb;
  localparam int unsigned LIMIT_CYCLES = 200_000;
  localparam int          ITEMS        = 700;
  localparam int          CALM_ITEMS   = 120;

  typedef enum {SEG_GOOD, SEG_REPLAY, SEG_CORRUPT} seg_mode_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  bit                     calm       = 1'b0;
  int                     n_sent     = 0;

  segment_tracker tracker = new();

  always #5 clk = ~clk;

  stop_and_wait_segment_receiver_unit #(
    .PAYLOAD_BYTES(SEG_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // result side: random stall bursts, none while calm
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 11) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // unpack and check every accepted result beat
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got                  = '0;
      got.kind             = out_tuser;
      got.out_byte         = out_tdata[7:0];
      got.byte_index       = out_tdata[18:8];
      got.status           = out_tdata[20:19];
      got.send_ack         = out_tdata[21];
      got.ack_number       = out_tdata[22];
      got.ack_checksum     = out_tdata[23];
      got.packets_accepted = out_tdata[55:24];
      got.transfer_done    = out_tdata[56];
      got.last_of_run      = out_tlast;
      tracker.match_result(got);
    end
  end

  function automatic item_t header_beat(logic [31:0] seq, logic [31:0] ack, logic [31:0] chk,
                                        logic last, logic [31:0] len);
    item_t it;
    it.operation       = OP_HEADER;
    it.seq_no          = seq;
    it.ack_no          = ack;
    it.header_checksum = chk;
    it.last_segment    = last;
    it.payload_length  = len;
    it.data_byte       = 8'($urandom);
    return it;
  endfunction

  // payload beat; header fields carry junk the receiver must ignore
  function automatic item_t payload_beat(logic [7:0] b);
    item_t it;
    it.operation       = OP_PAYLOAD;
    it.seq_no          = $urandom;
    it.ack_no          = $urandom;
    it.header_checksum = $urandom;
    it.last_segment    = 1'($urandom_range(0, 1));
    it.payload_length  = $urandom;
    it.data_byte       = b;
    return it;
  endfunction

  // short lengths in four of ten picks, with clamp edges, zero and wild values mixed in
  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 9))
      0: return {1'b1, 31'($urandom)};
      1: return SEG_BYTES;
      2: return SEG_BYTES - 1;
      3: return SEG_BYTES + $urandom_range(1, 100);
      4: return $urandom;
      5: return 32'd0;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // one beat on the input side, with an occasional gap ahead of it
  task automatic send_beat(input item_t it);
    int gap;
    if (!calm && $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.operation;
    in_tdata  <= {7'b0, it.data_byte, it.payload_length, it.last_segment,
                  it.header_checksum, it.ack_no, it.seq_no};
    do @(posedge clk); while (!in_tready);
    tracker.take_beat(it);
    n_sent++;
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1)) begin
      send_beat(payload_beat(8'($urandom)));
    end else begin
      send_beat(header_beat($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                            pick_len()));
    end
  endtask

  // segment start with a consistent checksum, bent as the mode says, cut after nbytes
  task automatic send_segment(input seg_mode_t mode, input logic [31:0] len, input int nbytes);
    logic [7:0]  body [SEG_BYTES];
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] chk;
    logic        last;
    ack  = $urandom;
    last = 1'($urandom_range(0, 1));
    seq  = {31'b0, tracker.want_bit};
    if (mode == SEG_REPLAY) begin
      seq = $urandom_range(0, 1) ? {31'b0, ~tracker.want_bit} : 32'($urandom);
    end
    chk = seq ^ ack ^ {31'b0, last} ^ len;
    foreach (body[i]) begin
      body[i] = 8'($urandom);
      chk     = chk ^ {{24{body[i][7]}}, body[i]};
    end
    if (mode == SEG_CORRUPT) chk = chk ^ (32'h1 << $urandom_range(0, 31));
    send_beat(header_beat(seq, ack, chk, last, len));
    for (int i = 0; i < nbytes; i++) send_beat(payload_beat(body[i]));
  endtask

  // main sequence
  initial begin
    seg_mode_t mode;
    int        pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // payload before any header
    send_beat(payload_beat(8'h80));
    send_beat(payload_beat(8'h7F));
    send_beat(payload_beat(8'hFF));
    // header inside a segment, negative length clamps to zero
    send_beat(header_beat(32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h8000_0000));
    send_beat(payload_beat(8'h00));
    // largest positive length clamps to the segment size
    send_beat(header_beat(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF));
    send_beat(payload_beat(8'h00));
    send_beat(payload_beat(8'hFF));
    send_beat(payload_beat(8'h80));
    send_beat(payload_beat(8'h7F));
    send_beat(header_beat(32'h1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, SEG_BYTES + 1));
    send_beat(payload_beat(8'h55));
    send_beat(header_beat(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'd1));
    send_beat(payload_beat(8'hAA));
    send_beat(payload_beat(8'h01));
    send_beat(header_beat(32'hFFFF_FFFF, 32'h1, 32'h1, 1'b1, 32'd0));
    send_beat(payload_beat(8'hFE));
    send_beat(header_beat(32'h0, 32'h0, 32'h0, 1'b0, SEG_BYTES - 1));
    send_beat(payload_beat(8'h3C));

    // sender holds off until the receiver has drained
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.outbox.size() != 0);

    // segment starts with random content and noise between, no idling at the end
    while (n_sent < ITEMS) begin
      calm = (n_sent >= ITEMS - CALM_ITEMS) || ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 3)) send_noise();
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        mode = SEG_GOOD;
      end else if (pick < 8) begin
        mode = SEG_REPLAY;
      end else begin
        mode = SEG_CORRUPT;
      end
      send_segment(mode, pick_len(), $urandom_range(0, 40));
    end

    // drain and let the pipeline settle
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.outbox.size() != 0);
    repeat (8) @(posedge clk);
    if (tracker.bad_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end
endmodule
